/* src/fsh_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and fixed-point helpers for the error-diffusion halftoner
package fsh_pkg;

  localparam int PIX_W    = 8;
  localparam int ERR_W    = 14;
  localparam int FRAC_W   = 4;
  localparam int SUM_W    = 18;
  localparam int IMG_W_W  = 12;
  localparam int IMG_H_W  = 16;
  localparam int MAXV_W   = 8;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;

  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [1:0]              reg_idx_t;

  localparam reg_idx_t REG_IMAGE_WIDTH  = 2'd0;
  localparam reg_idx_t REG_IMAGE_HEIGHT = 2'd1;
  localparam reg_idx_t REG_MAX_VALUE    = 2'd2;

  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 12'd640;
  localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 16'd480;
  localparam logic [MAXV_W-1:0]  MAX_VALUE_RST    = 8'd255;

  localparam sum_t SUM_ERR_MAX = sum_t'(2**(ERR_W-1) - 1);
  localparam sum_t SUM_ERR_MIN = -sum_t'(2**(ERR_W-1));

  // raster position of one pixel
  typedef struct packed {
    logic first_row;
    logic last_row;
    logic last_col;
    logic col_nz;
  } pos_t;

  // line store write requests from the diffusion stage
  typedef struct packed {
    logic main_we;
    logic pend_we;
  } wr_ctl_t;

  function automatic err_t sat_err(input sum_t v);
    err_t r;
    if (v > SUM_ERR_MAX) begin
      r = err_t'(SUM_ERR_MAX);
    end else if (v < SUM_ERR_MIN) begin
      r = err_t'(SUM_ERR_MIN);
    end else begin
      r = err_t'(v);
    end
    return r;
  endfunction

  // floor division by 16
  function automatic err_t share16(input sum_t prod);
    sum_t sh;
    sh = prod >>> FRAC_W;
    return err_t'(sh);
  endfunction

endpackage

/* src/fsh_raster.sv */
`timescale 1ns / 1ps
// raster column and row counters with width and height clamping
module fsh_raster #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  logic [fsh_pkg::IMG_W_W-1:0]       image_width,
  input  logic [fsh_pkg::IMG_H_W-1:0]       image_height,
  output logic [$clog2(MAX_WIDTH)-1:0]      x,
  output fsh_pkg::pos_t                     pos
);
  import fsh_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int LW = (AW + 1 > IMG_W_W) ? AW + 1 : IMG_W_W;
  localparam logic [LW-1:0] MAX_W_EXT = LW'(MAX_WIDTH);

  logic [AW-1:0]      column_r, column_nxt;
  logic [IMG_H_W-1:0] row_r, row_nxt;
  logic [LW-1:0]      w_ext, last_ext;
  logic [AW-1:0]      last_x;
  logic [IMG_H_W-1:0] last_y;
  logic               last_col, last_row;

  assign w_ext = LW'(image_width);

  always_comb begin
    priority if (w_ext == '0) begin
      last_ext = '0;
    end else if (w_ext > MAX_W_EXT) begin
      last_ext = MAX_W_EXT - LW'(1);
    end else begin
      last_ext = w_ext - LW'(1);
    end
  end

  assign last_x   = last_ext[AW-1:0];
  assign last_y   = (image_height == '0) ? '0 : image_height - IMG_H_W'(1);
  assign last_col = (column_r >= last_x);
  assign last_row = (row_r >= last_y);
  assign x        = last_col ? last_x : column_r;

  assign pos.first_row = (row_r == '0);
  assign pos.last_row  = last_row;
  assign pos.last_col  = last_col;
  assign pos.col_nz    = (x != '0);

  always_comb begin
    column_nxt = column_r;
    row_nxt    = row_r;
    if (step) begin
      if (last_col) begin
        column_nxt = '0;
        row_nxt    = last_row ? '0 : row_r + IMG_H_W'(1);
      end else begin
        column_nxt = x + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      row_r    <= '0;
    end else begin
      column_r <= column_nxt;
      row_r    <= row_nxt;
    end
  end

endmodule

/* src/fsh_line_buf.sv */
`timescale 1ns / 1ps
// next-row error line store with clearing sweep, deferred write slot and read forwarding
module fsh_line_buf #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  output logic                          clr_busy,
  input  logic                          rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
  output fsh_pkg::err_t                 rd_data,
  input  fsh_pkg::wr_ctl_t              wr,
  input  logic [$clog2(MAX_WIDTH)-1:0]  main_addr,
  input  fsh_pkg::err_t                 main_data,
  input  logic [$clog2(MAX_WIDTH)-1:0]  pend_addr,
  input  fsh_pkg::err_t                 pend_data
);
  import fsh_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam logic [AW-1:0] CLR_LAST = AW'(MAX_WIDTH - 1);

  err_t mem [MAX_WIDTH];

  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;
  logic          def_v_r, def_v_nxt;
  logic [AW-1:0] def_addr_r, def_addr_nxt;
  err_t          def_data_r, def_data_nxt;
  logic          we;
  logic [AW-1:0] wa;
  err_t          wd;
  logic          fwd_hit, fwd_hit_r;
  err_t          fwd_data, fwd_data_r;
  err_t          mem_q_r;

  assign clr_busy = clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == CLR_LAST) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // single write port: sweep, then this beat's write, then the parked end-of-row entry
  always_comb begin
    we = 1'b0;
    wa = def_addr_r;
    wd = def_data_r;
    priority if (clr_busy_r) begin
      we = 1'b1;
      wa = clr_addr_r;
      wd = '0;
    end else if (wr.main_we) begin
      we = 1'b1;
      wa = main_addr;
      wd = main_data;
    end else if (def_v_r) begin
      we = 1'b1;
    end
  end

  always_comb begin
    def_v_nxt    = def_v_r;
    def_addr_nxt = def_addr_r;
    def_data_nxt = def_data_r;
    if (wr.pend_we) begin
      def_v_nxt    = 1'b1;
      def_addr_nxt = pend_addr;
      def_data_nxt = pend_data;
    end else if (!clr_busy_r && !wr.main_we) begin
      def_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_v_r <= 1'b0;
    end else begin
      def_v_r <= def_v_nxt;
    end
    def_addr_r <= def_addr_nxt;
    def_data_r <= def_data_nxt;
  end

  // newest data for the read address that the memory array does not hold yet
  always_comb begin
    fwd_hit  = 1'b1;
    fwd_data = def_data_r;
    priority if (wr.main_we && main_addr == rd_addr) begin
      fwd_data = main_data;
    end else if (wr.pend_we && pend_addr == rd_addr) begin
      fwd_data = pend_data;
    end else if (def_v_r && def_addr_r == rd_addr) begin
      fwd_data = def_data_r;
    end else begin
      fwd_hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (rd_en) begin
      fwd_hit_r <= fwd_hit;
    end
    if (rd_en) begin
      fwd_data_r <= fwd_data;
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : mem_q_r;

endmodule

/* src/fsh_diffuse.sv */
`timescale 1ns / 1ps
// threshold, quantization error and 7/3/5/1 share split with the in-row error registers
module fsh_diffuse (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic [fsh_pkg::PIX_W-1:0]    pixel,
  input  fsh_pkg::err_t                cur,
  input  fsh_pkg::pos_t                pos,
  input  logic [fsh_pkg::MAXV_W-1:0]   max_value,
  output logic                         ink,
  output fsh_pkg::wr_ctl_t             wr,
  output fsh_pkg::err_t                main_data,
  output fsh_pkg::err_t                pend_data
);
  import fsh_pkg::*;

  err_t right_r, right_nxt;
  err_t diag_r, diag_nxt;
  err_t below_r, below_nxt;
  err_t cur_eff, v, e, s7, s3, s5, s1;
  sum_t pix_s, full, v_s, e_s;

  assign cur_eff = pos.first_row ? '0 : cur;
  assign pix_s   = sum_t'({pixel, {FRAC_W{1'b0}}});
  assign full    = sum_t'({max_value, {FRAC_W{1'b0}}});
  assign v       = sat_err(pix_s + sum_t'(cur_eff) + sum_t'(right_r));
  assign v_s     = sum_t'(v);
  assign ink     = (v_s > 0) && ((v_s <<< 1) > full);
  assign e       = sat_err(v_s - (ink ? full : '0));
  assign e_s     = sum_t'(e);

  assign s7 = share16((e_s <<< 3) - e_s);
  assign s3 = share16((e_s <<< 1) + e_s);
  assign s5 = share16((e_s <<< 2) + e_s);
  assign s1 = share16(e_s);

  // left neighbor below is finished by this pixel's 3/16 share
  assign main_data = sat_err(sum_t'(below_r) + sum_t'(s3));
  assign pend_data = sat_err(sum_t'(diag_r) + sum_t'(s5));

  assign wr.main_we = adv && !pos.last_row && pos.col_nz;
  assign wr.pend_we = adv && !pos.last_row && pos.last_col;

  always_comb begin
    right_nxt = right_r;
    diag_nxt  = diag_r;
    below_nxt = below_r;
    if (adv) begin
      if (pos.last_col) begin
        right_nxt = '0;
        diag_nxt  = '0;
        below_nxt = '0;
      end else begin
        right_nxt = s7;
        diag_nxt  = s1;
        below_nxt = pend_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_r <= '0;
      diag_r  <= '0;
      below_r <= '0;
    end else begin
      right_r <= right_nxt;
      diag_r  <= diag_nxt;
      below_r <= below_nxt;
    end
  end

endmodule

/* src/floyd_steinberg_halftone_top.sv */
`timescale 1ns / 1ps
// Floyd-Steinberg error-diffusion halftoner: one grey pixel in, one ink bit out, raster
// order. Throughput is one pixel per clock while results are taken and the line store
// is not sweeping; an accepted pixel passes the input register, then the result register,
// to out_tvalid, and the block takes one more pixel while that result waits, then holds
// in_tready low until the result is taken. The per-pixel figure is set by the single
// line-store memory (one read at accept, one write port per cycle, the end-of-row entry
// parked until a cycle with the port free) and the short error path between the input
// and result registers. After reset the line store is swept to zero with in_tready low;
// register writes are taken during the sweep. Registers: image_width at 0x0,
// image_height at 0x4, max_value at 0x8; write them only while the block is idle.
module floyd_steinberg_halftone_top #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [fsh_pkg::IN_TDATA_W-1:0]     in_tdata,     // [7:0] pixel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [fsh_pkg::OUT_TDATA_W-1:0]    out_tdata,    // [0] ink, [7:1] zero
  output logic                               out_tlast,    // frame_end
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [fsh_pkg::CFG_AW-1:0]         cfg_paddr,
  input  logic [fsh_pkg::CFG_DW-1:0]         cfg_pwdata,
  output logic [fsh_pkg::CFG_DW-1:0]         cfg_prdata,
  output logic                               cfg_pready
);
  import fsh_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  logic [IMG_W_W-1:0] image_width_r;
  logic [IMG_H_W-1:0] image_height_r;
  logic [MAXV_W-1:0]  max_value_r;
  reg_idx_t           cfg_idx;
  logic               cfg_we;

  logic               in_acc, s1_adv, clr_busy;
  logic [AW-1:0]      x;
  pos_t               pos;
  logic               s1_v_r, s1_v_nxt;
  logic [PIX_W-1:0]   s1_pix_r;
  pos_t               s1_pos_r;
  logic [AW-1:0]      s1_x_r;
  err_t               cur, main_data, pend_data;
  wr_ctl_t            wr;
  logic               ink;
  logic               out_v_r, out_v_nxt;
  logic               out_ink_r, out_last_r;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_AW-1:2];
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= IMAGE_WIDTH_RST;
      image_height_r <= IMAGE_HEIGHT_RST;
      max_value_r    <= MAX_VALUE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_pwdata[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_pwdata[IMG_H_W-1:0];
        REG_MAX_VALUE:    max_value_r    <= cfg_pwdata[MAXV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_IMAGE_WIDTH:  cfg_prdata = CFG_DW'(image_width_r);
      REG_IMAGE_HEIGHT: cfg_prdata = CFG_DW'(image_height_r);
      REG_MAX_VALUE:    cfg_prdata = CFG_DW'(max_value_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // handshake
  assign s1_adv    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !clr_busy && (!s1_v_r || s1_adv);
  assign in_acc    = in_tvalid && in_tready;

  fsh_raster #(.MAX_WIDTH(MAX_WIDTH)) u_raster (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (in_acc),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .x            (x),
    .pos          (pos)
  );

  fsh_line_buf #(.MAX_WIDTH(MAX_WIDTH)) u_line_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr_busy  (clr_busy),
    .rd_en     (in_acc),
    .rd_addr   (x),
    .rd_data   (cur),
    .wr        (wr),
    .main_addr (s1_x_r - AW'(1)),
    .main_data (main_data),
    .pend_addr (s1_x_r),
    .pend_data (pend_data)
  );

  // input register
  assign s1_v_nxt = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
    if (in_acc) begin
      s1_pix_r <= in_tdata[PIX_W-1:0];
      s1_pos_r <= pos;
      s1_x_r   <= x;
    end
  end

  fsh_diffuse u_diffuse (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (s1_adv),
    .pixel     (s1_pix_r),
    .cur       (cur),
    .pos       (s1_pos_r),
    .max_value (max_value_r),
    .ink       (ink),
    .wr        (wr),
    .main_data (main_data),
    .pend_data (pend_data)
  );

  // result register
  assign out_v_nxt = s1_adv ? 1'b1 : (out_tready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
    if (s1_adv) begin
      out_ink_r  <= ink;
      out_last_r <= s1_pos_r.last_col && s1_pos_r.last_row;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_TDATA_W'(out_ink_r);
  assign out_tlast  = out_last_r;

endmodule
